[rtl/core/ptc_pkg.sv]
package ptc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF    = 20;

    localparam int TOL_WIDTH = 31;
    localparam int FRAC_BITS = 30;
    // low numerator bits fed into the long division after the top part
    localparam int LOW_BITS  = 31;
    // quotient bits kept: enough to hold up to 2^61 - 1
    localparam int QBITS     = LOW_BITS + FRAC_BITS;
    // weight working width: limited quotients and gamma fit here
    localparam int WW        = 63;

    localparam int VERTEX_ONE = 65536;
    localparam int TOL_RESET  = 1074;

    localparam logic [2:0] REG_AX  = 3'd0;
    localparam logic [2:0] REG_AY  = 3'd1;
    localparam logic [2:0] REG_BX  = 3'd2;
    localparam logic [2:0] REG_BY  = 3'd3;
    localparam logic [2:0] REG_CX  = 3'd4;
    localparam logic [2:0] REG_CY  = 3'd5;
    localparam logic [2:0] REG_TOL = 3'd6;

    localparam logic [2:0] CLS_OUTSIDE    = 3'd0;
    localparam logic [2:0] CLS_INTERIOR   = 3'd1;
    localparam logic [2:0] CLS_EDGE       = 3'd2;
    localparam logic [2:0] CLS_VERTEX     = 3'd3;
    localparam logic [2:0] CLS_UNASSIGNED = 3'd4;
    localparam logic [2:0] CLS_DEGENERATE = 3'd5;

endpackage

[rtl/core/ptc_qdiv.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Expects i_rem < i_den; produces QBITS quotient bits.
module ptc_qdiv import ptc_pkg::*; #(
    parameter int NW = 67
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NW-1:0]     i_rem,
    input  logic [LOW_BITS-1:0] i_low,
    input  logic [NW-1:0]     i_den,
    output logic [QBITS-1:0]  o_quot
);

    logic [NW-1:0]    r_rem  [QBITS];
    logic [NW-1:0]    r_den  [QBITS];
    logic [QBITS-1:0] r_bits [QBITS];
    logic [QBITS-1:0] r_q    [QBITS];

    logic [NW-1:0]    n_rem  [QBITS];
    logic [QBITS-1:0] n_bits [QBITS];
    logic [QBITS-1:0] n_q    [QBITS];

    always_comb begin
        logic [NW-1:0]    p_rem;
        logic [NW-1:0]    p_den;
        logic [QBITS-1:0] p_bits;
        logic [QBITS-1:0] p_q;
        logic [NW:0]      t;
        logic [NW:0]      d;
        for (int k = 0; k < QBITS; k++) begin
            if (k == 0) begin
                p_rem  = i_rem;
                p_den  = i_den;
                p_bits = {i_low, {FRAC_BITS{1'b0}}};
                p_q    = '0;
            end else begin
                p_rem  = r_rem[k-1];
                p_den  = r_den[k-1];
                p_bits = r_bits[k-1];
                p_q    = r_q[k-1];
            end
            t = {p_rem, p_bits[QBITS-1]};
            d = {1'b0, p_den};
            n_bits[k] = {p_bits[QBITS-2:0], 1'b0};
            if (t >= d) begin
                n_rem[k] = NW'(t - d);
                n_q[k]   = {p_q[QBITS-2:0], 1'b1};
            end else begin
                n_rem[k] = t[NW-1:0];
                n_q[k]   = {p_q[QBITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QBITS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_bits[k] <= n_bits[k];
                r_q[k]    <= n_q[k];
                r_den[k]  <= (k == 0) ? i_den : r_den[k-1];
            end
        end
    end

    assign o_quot = r_q[QBITS-1];

endmodule

[rtl/core/point_triangle_classify_core.sv]
// Pipeline from item accept to result valid: 4 front stages,
//   61 divider stages, 2 finishing stages.
// Throughput: one item per cycle; the whole pipe holds while the output
//   register is full and stalled.
// Reset (i_rst_n low, synchronous): valid bits cleared, config registers to defaults.
module point_triangle_classify_core import ptc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [((COORD_WIDTH > TOL_WIDTH) ? COORD_WIDTH : TOL_WIDTH)-1:0] i_cfg_data,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic [ID_WIDTH-1:0]           i_point_id,
    // result item channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_point_class,
    output logic signed [31:0]            o_weight_a,
    output logic signed [31:0]            o_weight_b,
    output logic signed [31:0]            o_weight_c,
    output logic [ID_WIDTH-1:0]           o_result_id
);

    localparam int CW  = COORD_WIDTH;
    localparam int DFW = CW + 1;        // vertex/point differences
    localparam int PW  = 2 * DFW;       // exact products
    localparam int NW  = PW + 1;        // numerators and determinant

    localparam logic [WW-1:0]        LIMIT   = WW'(1) << (2 * FRAC_BITS);
    localparam logic signed [WW-1:0] ONE_Q   = WW'(1) << FRAC_BITS;
    localparam logic signed [WW-1:0] SAT_MAX = WW'(32'h7FFF_FFFF);
    localparam logic signed [WW-1:0] SAT_MIN = -(WW'(1) << 31);

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        logic                degen;
        logic                sat_a;
        logic                sat_b;
        logic                neg_a;
        logic                neg_b;
    } t_side;

    // global pipe advance: everything moves unless the output is held
    logic en;
    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // ---------------- configuration registers ----------------
    logic signed [CW-1:0]    r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [TOL_WIDTH-1:0]    r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax  <= '0;
            r_ay  <= '0;
            r_bx  <= CW'(VERTEX_ONE);
            r_by  <= '0;
            r_cx  <= '0;
            r_cy  <= CW'(VERTEX_ONE);
            r_tol <= TOL_WIDTH'(TOL_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AX:  r_ax  <= i_cfg_data[CW-1:0];
                REG_AY:  r_ay  <= i_cfg_data[CW-1:0];
                REG_BX:  r_bx  <= i_cfg_data[CW-1:0];
                REG_BY:  r_by  <= i_cfg_data[CW-1:0];
                REG_CX:  r_cx  <= i_cfg_data[CW-1:0];
                REG_CY:  r_cy  <= i_cfg_data[CW-1:0];
                REG_TOL: r_tol <= i_cfg_data[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [DFW-1:0] sub_c(input logic signed [CW-1:0] x,
                                                    input logic signed [CW-1:0] y);
        sub_c = $signed({x[CW-1], x}) - $signed({y[CW-1], y});
    endfunction

    function automatic logic signed [NW-1:0] add_p(input logic signed [PW-1:0] x,
                                                   input logic signed [PW-1:0] y);
        add_p = $signed({x[PW-1], x}) + $signed({y[PW-1], y});
    endfunction

    function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] x);
        mag = x[NW-1] ? NW'(-x) : x;
    endfunction

    // ---------------- stage 1: differences ----------------
    logic                  r1_valid;
    logic signed [DFW-1:0] r1_dpx, r1_dpy, r1_dbcy, r1_dcbx, r1_dcay, r1_dacx, r1_dacy;
    logic [ID_WIDTH-1:0]   r1_id;

    // ---------------- stage 2: products ----------------
    logic                  r2_valid;
    logic signed [PW-1:0]  r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6;
    logic [ID_WIDTH-1:0]   r2_id;

    // ---------------- stage 3: sums ----------------
    logic                  r3_valid;
    logic signed [NW-1:0]  r3_na, r3_nb, r3_den;
    logic [ID_WIDTH-1:0]   r3_id;

    // ---------------- stage 4: magnitudes, divider setup ----------------
    logic                  r4_valid;
    logic [NW-1:0]         r4_rem_a, r4_rem_b, r4_dmag;
    logic [LOW_BITS-1:0]   r4_low_a, r4_low_b;
    t_side                 r4_side;

    logic [NW-1:0] ma, mb, md;
    always_comb begin
        ma = mag(r3_na);
        mb = mag(r3_nb);
        md = mag(r3_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dpx  <= sub_c(i_point_x, r_cx);
            r1_dpy  <= sub_c(i_point_y, r_cy);
            r1_dbcy <= sub_c(r_by, r_cy);
            r1_dcbx <= sub_c(r_cx, r_bx);
            r1_dcay <= sub_c(r_cy, r_ay);
            r1_dacx <= sub_c(r_ax, r_cx);
            r1_dacy <= sub_c(r_ay, r_cy);
            r1_id   <= i_point_id;

            r2_p1 <= r1_dbcy * r1_dpx;
            r2_p2 <= r1_dcbx * r1_dpy;
            r2_p3 <= r1_dcay * r1_dpx;
            r2_p4 <= r1_dacx * r1_dpy;
            r2_p5 <= r1_dbcy * r1_dacx;
            r2_p6 <= r1_dcbx * r1_dacy;
            r2_id <= r1_id;

            r3_na  <= add_p(r2_p1, r2_p2);
            r3_nb  <= add_p(r2_p3, r2_p4);
            r3_den <= add_p(r2_p5, r2_p6);
            r3_id  <= r2_id;

            // top part of |n| * 2^30 / 2^61; at or above d the quotient
            // is past 2^61 and the limit applies
            r4_rem_a      <= ma >> LOW_BITS;
            r4_rem_b      <= mb >> LOW_BITS;
            r4_low_a      <= ma[LOW_BITS-1:0];
            r4_low_b      <= mb[LOW_BITS-1:0];
            r4_dmag       <= md;
            r4_side.id    <= r3_id;
            r4_side.degen <= (r3_den == '0);
            r4_side.sat_a <= ((ma >> LOW_BITS) >= md);
            r4_side.sat_b <= ((mb >> LOW_BITS) >= md);
            r4_side.neg_a <= r3_na[NW-1] != r3_den[NW-1];
            r4_side.neg_b <= r3_nb[NW-1] != r3_den[NW-1];
        end
    end

    // ---------------- divider stages ----------------
    logic [QBITS-1:0] q_a, q_b;

    ptc_qdiv #(.NW(NW)) u_div_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r4_rem_a),
        .i_low  (r4_low_a),
        .i_den  (r4_dmag),
        .o_quot (q_a)
    );

    ptc_qdiv #(.NW(NW)) u_div_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r4_rem_b),
        .i_low  (r4_low_b),
        .i_den  (r4_dmag),
        .o_quot (q_b)
    );

    // side data rides alongside the divider
    logic [QBITS-1:0] r_dv_valid;
    t_side            r_dv_side [QBITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid <= '0;
        end else if (en) begin
            r_dv_valid <= {r_dv_valid[QBITS-2:0], r4_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r4_side;
            for (int k = 1; k < QBITS; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // ---------------- finish A: limit, sign, gamma ----------------
    logic                 r5_valid;
    logic signed [WW-1:0] r5_a, r5_b, r5_g;
    t_side                r5_side;

    logic [WW-1:0]        qa_lim, qb_lim;
    logic signed [WW-1:0] a_s, b_s;
    t_side                dv_out;

    always_comb begin
        dv_out = r_dv_side[QBITS-1];
        qa_lim = (dv_out.sat_a || (WW'(q_a) > LIMIT)) ? LIMIT : WW'(q_a);
        qb_lim = (dv_out.sat_b || (WW'(q_b) > LIMIT)) ? LIMIT : WW'(q_b);
        a_s    = dv_out.neg_a ? -$signed(qa_lim) : $signed(qa_lim);
        b_s    = dv_out.neg_b ? -$signed(qb_lim) : $signed(qb_lim);
    end

    // ---------------- finish B: classify, saturate ----------------
    logic signed [WW-1:0] tol_s, abs_a, abs_b, abs_g;
    logic                 outside;
    logic [1:0]           nz;
    logic [2:0]           n_cls;

    function automatic logic [31:0] sat32(input logic signed [WW-1:0] v);
        if (v > SAT_MAX) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    always_comb begin
        tol_s   = $signed(WW'(r_tol));
        abs_a   = r5_a[WW-1] ? -r5_a : r5_a;
        abs_b   = r5_b[WW-1] ? -r5_b : r5_b;
        abs_g   = r5_g[WW-1] ? -r5_g : r5_g;
        outside = (r5_a < -tol_s) || (r5_b < -tol_s) || (r5_g < -tol_s);
        nz      = 2'(abs_a <= tol_s) + 2'(abs_b <= tol_s) + 2'(abs_g <= tol_s);
        case (nz)
            2'd0:    n_cls = CLS_INTERIOR;
            2'd1:    n_cls = CLS_EDGE;
            2'd2:    n_cls = CLS_VERTEX;
            default: n_cls = CLS_UNASSIGNED;
        endcase
        if (outside) begin
            n_cls = CLS_OUTSIDE;
        end
        if (r5_side.degen) begin
            n_cls = CLS_DEGENERATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid    <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r5_valid    <= r_dv_valid[QBITS-1];
            o_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_a    <= a_s;
            r5_b    <= b_s;
            r5_g    <= ONE_Q - a_s - b_s;
            r5_side <= dv_out;

            o_point_class <= n_cls;
            o_result_id   <= r5_side.id;
            // a degenerate triangle reports zero weights
            o_weight_a    <= r5_side.degen ? '0 : sat32(r5_a);
            o_weight_b    <= r5_side.degen ? '0 : sat32(r5_b);
            o_weight_c    <= r5_side.degen ? '0 : sat32(r5_g);
        end
    end

endmodule
